FILE: rtl/acc_pkg.sv
// shared types and widths for the box versus circle collision pipeline
// no dependencies; used by every module under rtl
package acc_pkg;

    // working width for offsets, extents and clamped points (signed)
    localparam int VEC_W  = 36;
    // magnitude of the box-to-circle vector
    localparam int MAG_W  = 35;
    // low slice width for the split square
    localparam int LO_W   = 18;
    // squared distance width
    localparam int DD_W   = 72;
    // root width, one bit resolved per sqrt stage
    localparam int ROOT_W = 36;
    // normal scale is 2 to this power (Q2.14)
    localparam int NORM_SH = 14;
    // quotient bits, one per divider stage
    localparam int Q_W    = NORM_SH + 1;
    // dividend and remainder width in the divider
    localparam int DIV_W  = MAG_W + NORM_SH + 2;
    // result field widths
    localparam int PEN_W  = 32;
    localparam int NRM_W  = 16;

    // side data carried beside the squared distance and the root
    typedef struct packed {
        logic              hit;
        logic              in_box;
        logic              sx;
        logic              sy;
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic [31:0]       r2;
    } acc_side_t;

    // side data carried through the divider
    typedef struct packed {
        logic              hit;
        logic              flip_x;
        logic              flip_y;
        logic              zero;
        logic [PEN_W-1:0]  pen;
    } acc_div_side_t;

endpackage

FILE: rtl/acc_front.sv
// front stages: box center offset, clamp, face push, split squares, hit test
// depends on acc_pkg
module acc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [31:0]                box_min_x,
    input  logic signed [31:0]                box_min_y,
    input  logic signed [31:0]                box_max_x,
    input  logic signed [31:0]                box_max_y,
    input  logic signed [31:0]                circle_center_x,
    input  logic signed [31:0]                circle_center_y,
    input  logic        [30:0]                circle_radius,
    output logic                              out_valid,
    output acc_pkg::acc_side_t                out_side,
    output logic [acc_pkg::DD_W-1:0]          out_dd
);

    localparam int VW = acc_pkg::VEC_W;
    localparam int MW = acc_pkg::MAG_W;
    localparam int LW = acc_pkg::LO_W;
    localparam int HW = MW - LW;

    // stage a: doubled offsets and extents
    logic                 va_reg;
    logic signed [VW-1:0] nx_a_reg, ny_a_reg, ex_a_reg, ey_a_reg;
    logic [31:0]          r2_a_reg;
    logic signed [VW-1:0] nx_a_next, ny_a_next, ex_a_next, ey_a_next;

    always_comb begin
        nx_a_next = (VW'(circle_center_x) <<< 1) - (VW'(box_min_x) + VW'(box_max_x));
        ny_a_next = (VW'(circle_center_y) <<< 1) - (VW'(box_min_y) + VW'(box_max_y));
        ex_a_next = VW'(box_max_x) - VW'(box_min_x);
        ey_a_next = VW'(box_max_y) - VW'(box_min_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_a_reg <= nx_a_next;
            ny_a_reg <= ny_a_next;
            ex_a_reg <= ex_a_next;
            ey_a_reg <= ey_a_next;
            r2_a_reg <= {circle_radius, 1'b0};
        end
    end

    // stage b: clamp to the half extents
    logic                 vb_reg, in_b_reg;
    logic signed [VW-1:0] nx_b_reg, ny_b_reg, ex_b_reg, ey_b_reg, px_b_reg, py_b_reg;
    logic [31:0]          r2_b_reg;
    logic signed [VW-1:0] px_b_next, py_b_next;

    always_comb begin
        px_b_next = (nx_a_reg < -ex_a_reg) ? -ex_a_reg : nx_a_reg;
        if (px_b_next > ex_a_reg) begin
            px_b_next = ex_a_reg;
        end
        py_b_next = (ny_a_reg < -ey_a_reg) ? -ey_a_reg : ny_a_reg;
        if (py_b_next > ey_a_reg) begin
            py_b_next = ey_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_b_reg <= nx_a_reg;
            ny_b_reg <= ny_a_reg;
            ex_b_reg <= ex_a_reg;
            ey_b_reg <= ey_a_reg;
            px_b_reg <= px_b_next;
            py_b_reg <= py_b_next;
            in_b_reg <= (px_b_next == nx_a_reg) && (py_b_next == ny_a_reg);
            r2_b_reg <= r2_a_reg;
        end
    end

    // stage c: when inside, push along the axis of the larger center offset, form the vector
    logic                 vc_reg, in_c_reg, sx_c_reg, sy_c_reg;
    logic [MW-1:0]        mx_c_reg, my_c_reg;
    logic [31:0]          r2_c_reg;
    logic [VW-1:0]        anx, any_c;
    logic signed [VW-1:0] pxa, pya, vx, vy;

    always_comb begin
        anx   = nx_b_reg[VW-1] ? VW'(-nx_b_reg) : VW'(nx_b_reg);
        any_c = ny_b_reg[VW-1] ? VW'(-ny_b_reg) : VW'(ny_b_reg);
        pxa   = px_b_reg;
        pya   = py_b_reg;
        if (in_b_reg) begin
            if (anx > any_c) begin
                pxa = (px_b_reg > 0) ? ex_b_reg : -ex_b_reg;
            end else begin
                pya = (py_b_reg > 0) ? ey_b_reg : -ey_b_reg;
            end
        end
        vx = nx_b_reg - pxa;
        vy = ny_b_reg - pya;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_c_reg <= in_b_reg;
            sx_c_reg <= vx[VW-1];
            sy_c_reg <= vy[VW-1];
            mx_c_reg <= vx[VW-1] ? MW'(-vx) : MW'(vx);
            my_c_reg <= vy[VW-1] ? MW'(-vy) : MW'(vy);
            r2_c_reg <= r2_b_reg;
        end
    end

    // stage d: partial products of the squares and the radius square
    logic                 vd_reg, in_d_reg, sx_d_reg, sy_d_reg;
    logic [MW-1:0]        mx_d_reg, my_d_reg;
    logic [31:0]          r2_d_reg;
    logic [2*LW-1:0]      x00_reg, y00_reg;
    logic [LW+HW-1:0]     x01_reg, y01_reg;
    logic [2*HW-1:0]      x11_reg, y11_reg;
    logic [63:0]          rr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_d_reg <= in_c_reg;
            sx_d_reg <= sx_c_reg;
            sy_d_reg <= sy_c_reg;
            mx_d_reg <= mx_c_reg;
            my_d_reg <= my_c_reg;
            r2_d_reg <= r2_c_reg;
            x00_reg  <= mx_c_reg[LW-1:0] * mx_c_reg[LW-1:0];
            x01_reg  <= mx_c_reg[LW-1:0] * mx_c_reg[MW-1:LW];
            x11_reg  <= mx_c_reg[MW-1:LW] * mx_c_reg[MW-1:LW];
            y00_reg  <= my_c_reg[LW-1:0] * my_c_reg[LW-1:0];
            y01_reg  <= my_c_reg[LW-1:0] * my_c_reg[MW-1:LW];
            y11_reg  <= my_c_reg[MW-1:LW] * my_c_reg[MW-1:LW];
            rr_reg   <= r2_c_reg * r2_c_reg;
        end
    end

    // stage e: sum into the squared distance; hit when inside or within the radius
    localparam int DW = acc_pkg::DD_W;
    logic                 ve_reg;
    acc_pkg::acc_side_t   side_e_reg;
    logic [DW-1:0]        dd_e_reg;
    logic [DW-1:0]        dd_next;

    always_comb begin
        dd_next = (DW'(x11_reg) << (2 * LW)) + (DW'(x01_reg) << (LW + 1)) + DW'(x00_reg)
                + (DW'(y11_reg) << (2 * LW)) + (DW'(y01_reg) << (LW + 1)) + DW'(y00_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_e_reg          <= dd_next;
            side_e_reg.hit    <= in_d_reg || (dd_next <= DW'(rr_reg));
            side_e_reg.in_box <= in_d_reg;
            side_e_reg.sx     <= sx_d_reg;
            side_e_reg.sy     <= sy_d_reg;
            side_e_reg.mx     <= mx_d_reg;
            side_e_reg.my     <= my_d_reg;
            side_e_reg.r2     <= r2_d_reg;
        end
    end

    assign out_valid = ve_reg;
    assign out_side  = side_e_reg;
    assign out_dd    = dd_e_reg;

endmodule

FILE: rtl/acc_sqrt.sv
// pipelined integer square root, one root bit resolved per stage
// depends on acc_pkg
module acc_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  acc_pkg::acc_side_t                in_side,
    input  logic [acc_pkg::DD_W-1:0]          in_dd,
    output logic                              out_valid,
    output acc_pkg::acc_side_t                out_side,
    output logic [acc_pkg::ROOT_W-1:0]        out_root
);

    localparam int RW = acc_pkg::ROOT_W;
    localparam int DW = acc_pkg::DD_W;

    logic                 v_reg    [RW];
    acc_pkg::acc_side_t   side_reg [RW];
    logic [DW-1:0]        rem_reg  [RW];
    logic [RW-1:0]        res_reg  [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        localparam int B = RW - 1 - i;
        logic                 v_in;
        acc_pkg::acc_side_t   side_in;
        logic [DW-1:0]        rem_in;
        logic [RW-1:0]        res_in;
        logic [DW:0]          trial;
        logic                 take;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rem_in  = in_dd;
            assign res_in  = '0;
        end else begin : g_next
            assign v_in    = v_reg[i-1];
            assign side_in = side_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign res_in  = res_reg[i-1];
        end

        // trial term 2*res*2^b + 4^b against what is left
        always_comb begin
            trial = ((DW + 1)'(res_in) << (B + 1)) + ((DW + 1)'(1) << (2 * B));
            take  = {1'b0, rem_in} >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_in;
                rem_reg[i]  <= take ? DW'({1'b0, rem_in} - trial) : rem_in;
                res_reg[i]  <= take ? (res_in | (RW'(1) << B)) : res_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_side  = side_reg[RW-1];
    assign out_root  = res_reg[RW-1];

endmodule

FILE: rtl/acc_norm.sv
// penetration, pipelined restoring divide for the unit normal, result register
// depends on acc_pkg
module acc_norm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  acc_pkg::acc_side_t                in_side,
    input  logic [acc_pkg::ROOT_W-1:0]        in_root,
    output logic                              out_valid,
    output logic                              out_hit,
    output logic [acc_pkg::PEN_W-1:0]         out_pen,
    output logic [acc_pkg::NRM_W-1:0]         out_nx,
    output logic [acc_pkg::NRM_W-1:0]         out_ny
);

    localparam int RW = acc_pkg::ROOT_W;
    localparam int QW = acc_pkg::Q_W;
    localparam int VW = acc_pkg::DIV_W;
    localparam int PW = acc_pkg::PEN_W;
    localparam int NW = acc_pkg::NRM_W;
    localparam int SW = RW + 2;

    // stage p: penetration with floor halving and saturation, dividends
    logic                  vp_reg;
    acc_pkg::acc_div_side_t sp_reg;
    logic [VW-1:0]         nx_p_reg, ny_p_reg;
    logic [RW-1:0]         d_p_reg;
    logic signed [SW-1:0]  pen2, pen_half;
    logic [PW-1:0]         pen_sat;

    always_comb begin
        pen2     = $signed(SW'(in_side.r2)) - $signed(SW'(in_root));
        pen_half = pen2 >>> 1;
        if (pen_half[SW-1:PW-1] != {(SW - PW + 1){pen_half[SW-1]}}) begin
            pen_sat = pen_half[SW-1] ? {1'b1, {(PW - 1){1'b0}}} : {1'b0, {(PW - 1){1'b1}}};
        end else begin
            pen_sat = pen_half[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sp_reg.hit    <= in_side.hit;
            sp_reg.flip_x <= in_side.sx ^ in_side.in_box;
            sp_reg.flip_y <= in_side.sy ^ in_side.in_box;
            sp_reg.zero   <= (in_root == '0);
            sp_reg.pen    <= pen_sat;
            d_p_reg       <= in_root;
            nx_p_reg      <= (VW'(in_side.mx) << acc_pkg::NORM_SH) + VW'(in_root >> 1);
            ny_p_reg      <= (VW'(in_side.my) << acc_pkg::NORM_SH) + VW'(in_root >> 1);
        end
    end

    // divider stages, one quotient bit per stage for each component
    logic                   v_reg  [QW];
    acc_pkg::acc_div_side_t s_reg  [QW];
    logic [RW-1:0]          d_reg  [QW];
    logic [VW-1:0]          rx_reg [QW];
    logic [VW-1:0]          ry_reg [QW];
    logic [QW-1:0]          qx_reg [QW];
    logic [QW-1:0]          qy_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int K = QW - 1 - i;
        logic                   v_in;
        acc_pkg::acc_div_side_t s_in;
        logic [RW-1:0]          d_in;
        logic [VW-1:0]          rx_in, ry_in, dsh;
        logic [QW-1:0]          qx_in, qy_in;
        logic                   tx, ty;

        if (i == 0) begin : g_first
            assign v_in  = vp_reg;
            assign s_in  = sp_reg;
            assign d_in  = d_p_reg;
            assign rx_in = nx_p_reg;
            assign ry_in = ny_p_reg;
            assign qx_in = '0;
            assign qy_in = '0;
        end else begin : g_next
            assign v_in  = v_reg[i-1];
            assign s_in  = s_reg[i-1];
            assign d_in  = d_reg[i-1];
            assign rx_in = rx_reg[i-1];
            assign ry_in = ry_reg[i-1];
            assign qx_in = qx_reg[i-1];
            assign qy_in = qy_reg[i-1];
        end

        always_comb begin
            dsh = VW'(d_in) << K;
            tx  = rx_in >= dsh;
            ty  = ry_in >= dsh;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[i]  <= s_in;
                d_reg[i]  <= d_in;
                rx_reg[i] <= tx ? rx_in - dsh : rx_in;
                ry_reg[i] <= ty ? ry_in - dsh : ry_in;
                qx_reg[i] <= tx ? (qx_in | (QW'(1) << K)) : qx_in;
                qy_reg[i] <= ty ? (qy_in | (QW'(1) << K)) : qy_in;
            end
        end
    end

    // result register: signs applied, misses and zero distance cleared
    logic                  vo_reg, hit_o_reg;
    logic [PW-1:0]         pen_o_reg;
    logic [NW-1:0]         nx_o_reg, ny_o_reg;
    logic [NW-1:0]         nx_next, ny_next;
    acc_pkg::acc_div_side_t s_last;

    always_comb begin
        s_last  = s_reg[QW-1];
        nx_next = s_last.flip_x ? NW'(-NW'(qx_reg[QW-1])) : NW'(qx_reg[QW-1]);
        ny_next = s_last.flip_y ? NW'(-NW'(qy_reg[QW-1])) : NW'(qy_reg[QW-1]);
        if (s_last.zero || !s_last.hit) begin
            nx_next = '0;
            ny_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_o_reg <= s_last.hit;
            pen_o_reg <= s_last.hit ? s_last.pen : '0;
            nx_o_reg  <= nx_next;
            ny_o_reg  <= ny_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_hit   = hit_o_reg;
    assign out_pen   = pen_o_reg;
    assign out_nx    = nx_o_reg;
    assign out_ny    = ny_o_reg;

endmodule

FILE: rtl/aabb_circle_collision.sv
// top level of the box versus circle collision pipeline
// depends on acc_pkg, acc_front, acc_sqrt, acc_norm
//
//  channel  dir  tdata                                 tuser
//  s_       in   box min/max x,y, center x,y, radius   -
//  m_       out  penetration, normal_x, normal_y       hit
//
// one word accepted per cycle while no result is held; the pipeline has the
// 36 root stages, 15 divider stages and 7 stages of clamp, square and result
// aresetn clears every stage valid bit; payload registers are not reset
// a held result freezes the whole pipeline, nothing is dropped or repeated
module aabb_circle_collision (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y, circle_center_x,
    // circle_center_y, circle_radius (31 bits), one zero pad bit
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // penetration, normal_x, normal_y
    output logic [63:0]  m_tdata,
    // hit
    output logic [0:0]   m_tuser
);

    logic                              en;
    logic                              f_valid, q_valid;
    acc_pkg::acc_side_t                f_side, q_side;
    logic [acc_pkg::DD_W-1:0]          f_dd;
    logic [acc_pkg::ROOT_W-1:0]        q_root;
    logic                              o_hit;
    logic [acc_pkg::PEN_W-1:0]         o_pen;
    logic [acc_pkg::NRM_W-1:0]         o_nx, o_ny;

    // pipeline moves whenever the result slot is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    acc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (s_tvalid),
        .box_min_x       (s_tdata[31:0]),
        .box_min_y       (s_tdata[63:32]),
        .box_max_x       (s_tdata[95:64]),
        .box_max_y       (s_tdata[127:96]),
        .circle_center_x (s_tdata[159:128]),
        .circle_center_y (s_tdata[191:160]),
        .circle_radius   (s_tdata[222:192]),
        .out_valid       (f_valid),
        .out_side        (f_side),
        .out_dd          (f_dd)
    );

    acc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_dd     (f_dd),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_root  (q_root)
    );

    acc_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_side   (q_side),
        .in_root   (q_root),
        .out_valid (m_tvalid),
        .out_hit   (o_hit),
        .out_pen   (o_pen),
        .out_nx    (o_nx),
        .out_ny    (o_ny)
    );

    assign m_tdata = {o_ny, o_nx, o_pen};
    assign m_tuser = o_hit;

`ifndef NO_ASSERTIONS
    // a miss carries no penetration and no normal
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result not cleared");

    // normal components stay within one unit
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[47:32]) <= 16'sd16384)
                   && ($signed(m_tdata[47:32]) >= -16'sd16384)
                   && ($signed(m_tdata[63:48]) <= 16'sd16384)
                   && ($signed(m_tdata[63:48]) >= -16'sd16384)))
        else $error("normal out of range");

    // a held result keeps the input side stalled
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is held");
`endif

endmodule

FILE: tb/aabb_circle_collision_tb.sv
// self-checking testbench for the box versus circle collision pipeline
// depends on acc_pkg and aabb_circle_collision; predicts each result word
// from the input word and compares in order of arrival
module aabb_circle_collision_tb;

    typedef struct packed {
        logic [30:0] radius;
        logic [31:0] cy;
        logic [31:0] cx;
        logic [31:0] max_y;
        logic [31:0] max_x;
        logic [31:0] min_y;
        logic [31:0] min_x;
    } pair_t;

    typedef struct packed {
        logic                       hit;
        logic [acc_pkg::PEN_W-1:0]  pen;
        logic [acc_pkg::NRM_W-1:0]  nx;
        logic [acc_pkg::NRM_W-1:0]  ny;
    } contact_t;

    localparam longint NORM_ONE = 64'sd16384;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    pair_t    pending_pairs[$];
    contact_t expected_contacts[$];
    int       mismatches;
    bit       stim_done;
    int       hold_off;
    int       burst_left;
    int       gap_left;
    int       sent_count;

    aabb_circle_collision DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // integer square root, floor, of a 72 bit value
    function automatic logic [acc_pkg::ROOT_W-1:0] isqrt(logic [acc_pkg::DD_W-1:0] x);
        logic [acc_pkg::ROOT_W-1:0] root;
        logic [acc_pkg::ROOT_W-1:0] cand;
        logic [acc_pkg::DD_W-1:0]   sq;
        root = '0;
        for (int b = acc_pkg::ROOT_W - 1; b >= 0; b--) begin
            cand = root | (acc_pkg::ROOT_W'(1) << b);
            sq = acc_pkg::DD_W'(cand) * acc_pkg::DD_W'(cand);
            if (sq <= x) root = cand;
        end
        return root;
    endfunction

    // one normal component, rounded half away from zero
    function automatic longint unit_comp(longint v, longint d);
        longint m;
        longint q;
        m = v < 0 ? -v : v;
        q = (m * NORM_ONE + d / 2) / d;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        longint t;
        t = v < lo ? lo : v;
        return t > hi ? hi : t;
    endfunction

    // contact prediction, all lengths doubled so the box center is exact
    function automatic contact_t predict_contact(pair_t p);
        contact_t c;
        longint mnx, mny, mxx, mxy, r2, offx, offy, ex, ey, px, py, vx, vy;
        longint mvx, mvy, pen, pen2, d;
        logic [acc_pkg::DD_W-1:0] dd;
        logic [acc_pkg::DD_W-1:0] rr;
        bit in_box;
        mnx = longint'($signed(p.min_x));
        mny = longint'($signed(p.min_y));
        mxx = longint'($signed(p.max_x));
        mxy = longint'($signed(p.max_y));
        r2 = longint'(p.radius) * 2;
        offx = 2 * longint'($signed(p.cx)) - (mnx + mxx);
        offy = 2 * longint'($signed(p.cy)) - (mny + mxy);
        ex = mxx - mnx;
        ey = mxy - mny;
        px = clamp(offx, -ex, ex);
        py = clamp(offy, -ey, ey);
        in_box = 0;
        c = '0;
        if (px == offx && py == offy) begin
            in_box = 1;
            if ((offx < 0 ? -offx : offx) > (offy < 0 ? -offy : offy))
                px = px > 0 ? ex : -ex;
            else
                py = py > 0 ? ey : -ey;
        end
        vx = offx - px;
        vy = offy - py;
        mvx = vx < 0 ? -vx : vx;
        mvy = vy < 0 ? -vy : vy;
        dd = acc_pkg::DD_W'(mvx) * acc_pkg::DD_W'(mvx)
           + acc_pkg::DD_W'(mvy) * acc_pkg::DD_W'(mvy);
        rr = acc_pkg::DD_W'(r2) * acc_pkg::DD_W'(r2);
        if (!in_box && dd > rr) return c;
        d = longint'(isqrt(dd));
        pen2 = r2 - d;
        pen = pen2 >= 0 ? pen2 / 2 : -((-pen2 + 1) / 2);
        if (pen > 64'sd2147483647) pen = 64'sd2147483647;
        if (pen < -64'sd2147483648) pen = -64'sd2147483648;
        c.hit = 1'b1;
        c.pen = acc_pkg::PEN_W'(pen);
        if (d != 0) begin
            c.nx = acc_pkg::NRM_W'(in_box ? -unit_comp(vx, d) : unit_comp(vx, d));
            c.ny = acc_pkg::NRM_W'(in_box ? -unit_comp(vy, d) : unit_comp(vy, d));
        end
        return c;
    endfunction

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_pair(pair_t p);
        pending_pairs.push_back(p);
    endtask

    // box of moderate size near a circle, so hits, misses and inside all occur
    task automatic push_near_pair(int span);
        pair_t p;
        int ox, oy, w, h;
        ox = $urandom_range(0, 2 * span) - span;
        oy = $urandom_range(0, 2 * span) - span;
        w = $urandom_range(0, span);
        h = $urandom_range(0, span);
        p.min_x = ox;
        p.min_y = oy;
        p.max_x = ox + w;
        p.max_y = oy + h;
        p.cx = ox + $urandom_range(0, 2 * span) - span / 2;
        p.cy = oy + $urandom_range(0, 2 * span) - span / 2;
        p.radius = 31'($urandom_range(0, span));
        push_pair(p);
    endtask

    // stimulus
    initial begin
        pair_t p;
        aresetn = 1'b0;
        stim_done = 0;
        // touching exactly, distance equals radius
        p = '{radius: 31'h10000, cy: 0, cx: 32'h30000, max_y: 32'h10000,
              max_x: 32'h20000, min_y: 0, min_x: 0};
        push_pair(p);
        // center inside, larger offset along x
        p = '{radius: 31'h8000, cy: 32'h8000, cx: 32'h18000, max_y: 32'h10000,
              max_x: 32'h20000, min_y: 0, min_x: 0};
        push_pair(p);
        // center inside, nearer to y face
        p.cx = 32'h10000; p.cy = 32'hc000;
        push_pair(p);
        // miss
        p = '{radius: 31'h100, cy: 32'h50000, cx: 32'h50000, max_y: 32'h10000,
              max_x: 32'h10000, min_y: 0, min_x: 0};
        push_pair(p);
        // degenerate point box with center on it: zero distance
        p = '{radius: 0, cy: 32'h4000, cx: 32'h4000, max_y: 32'h4000,
              max_x: 32'h4000, min_y: 32'h4000, min_x: 32'h4000};
        push_pair(p);
        // center on the box edge
        p = '{radius: 31'h7fffffff, cy: 0, cx: 32'h10000, max_y: 32'h10000,
              max_x: 32'h10000, min_y: 0, min_x: 0};
        push_pair(p);
        // inverted box on x
        p = '{radius: 31'h20000, cy: 0, cx: 0, max_y: 32'h10000,
              max_x: 32'hfffe0000, min_y: 0, min_x: 32'h20000};
        push_pair(p);
        // inverted box, center equal to extent
        p = '{radius: 31'h1, cy: 32'h0, cx: 32'h0, max_y: 32'h0,
              max_x: 32'hffff0000, min_y: 32'h0, min_x: 32'h10000};
        push_pair(p);
        // full range extremes
        p = '{radius: 31'h7fffffff, cy: 32'h80000000, cx: 32'h7fffffff,
              max_y: 32'h7fffffff, max_x: 32'h80000000, min_y: 32'h80000000,
              min_x: 32'h7fffffff};
        push_pair(p);
        p = '{radius: 31'h7fffffff, cy: 32'h7fffffff, cx: 32'h80000000,
              max_y: 32'h7fffffff, max_x: 32'h7fffffff, min_y: 32'h80000000,
              min_x: 32'h80000000};
        push_pair(p);
        p = '{radius: 0, cy: 32'hffffffff, cx: 32'hffffffff, max_y: 0, max_x: 0,
              min_y: 32'hffffffff, min_x: 32'hffffffff};
        push_pair(p);
        p = '{radius: 31'h7fffffff, cy: 32'h80000000, cx: 32'h80000000,
              max_y: 32'h80000000, max_x: 32'h80000000, min_y: 32'h80000000,
              min_x: 32'h80000000};
        push_pair(p);
        // random: mostly geometry near the box, some full-range noise
        for (int i = 0; i < 1300; i++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    p.min_x = rand32(); p.min_y = rand32();
                    p.max_x = rand32(); p.max_y = rand32();
                    p.cx = rand32(); p.cy = rand32();
                    p.radius = 31'(rand32());
                    push_pair(p);
                end
                2, 3: push_near_pair(1 << 30);
                4, 5: push_near_pair(1 << 20);
                default: push_near_pair($urandom_range(4, 1 << 17));
            endcase
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_pairs.size() == 0 && !s_tvalid);
        stim_done = 1;
    end

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
            sent_count <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_contacts.push_back(predict_contact(pair_t'(s_tdata[222:0])));
                sent_count <= sent_count + 1;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, pending_pairs.pop_front()};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the pipeline backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_off <= 0;
        end else begin
            if (hold_off == 0 && sent_count >= 300) begin
                hold_off <= 400;
                m_tready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else begin
                if (hold_off == 1) hold_off <= -1;
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // result check against the oldest prediction
    always @(posedge aclk) begin
        contact_t got;
        contact_t exp_c;
        if (!aresetn) begin
            mismatches <= 0;
        end else if (m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[31:0], m_tdata[47:32], m_tdata[63:48]};
            if (expected_contacts.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result word %h", got);
            end else begin
                exp_c = expected_contacts.pop_front();
                if (got !== exp_c) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: hit %b/%b pen %h/%h nx %h/%h ny %h/%h",
                                 exp_c.hit, got.hit, exp_c.pen, got.pen,
                                 exp_c.nx, got.nx, exp_c.ny, got.ny);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (expected_contacts.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_contacts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
